FILE: src/tun_pkg.sv
package tun_pkg;

    // normalized magnitudes lie in [0, 2^31)
    localparam int MAG_W  = 31;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SUM_W  = 64;
    localparam int ROOT_W = SUM_W / 2;
    // sqrt remainder stays below 2 * root + 1
    localparam int REM_W  = ROOT_W + 2;

endpackage

FILE: src/tun_sqrt_cell.sv
module tun_sqrt_cell (
    input  logic                       clk,
    input  logic                       en,
    input  logic [tun_pkg::SUM_W-1:0]  s_in,
    input  logic [tun_pkg::REM_W-1:0]  rem_in,
    input  logic [tun_pkg::ROOT_W-1:0] root_in,
    output logic [tun_pkg::SUM_W-1:0]  s_out,
    output logic [tun_pkg::REM_W-1:0]  rem_out,
    output logic [tun_pkg::ROOT_W-1:0] root_out
);
    import tun_pkg::*;

    logic [REM_W+1:0]  cur;
    logic [REM_W+1:0]  trial;
    logic              take;
    logic [SUM_W-1:0]  s_next;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_next;
    logic [SUM_W-1:0]  s_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;

    // one root bit per cell, two radicand bits brought down
    always_comb
    begin
        cur       = {rem_in, s_in[SUM_W-1 -: 2]};
        trial     = (REM_W+2)'({root_in, 2'b01});
        take      = (cur >= trial);
        rem_next  = take ? REM_W'(cur - trial) : cur[REM_W-1:0];
        root_next = {root_in[ROOT_W-2:0], take};
        s_next    = {s_in[SUM_W-3:0], 2'b00};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg    <= s_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign s_out    = s_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

FILE: src/tun_div_cell.sv
module tun_div_cell #(
    parameter int QUO_W = 15
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [tun_pkg::ROOT_W-1:0] m_in,
    input  logic [tun_pkg::ROOT_W-1:0] p_in,
    input  logic [QUO_W-1:0]           dl_in,
    input  logic [QUO_W-1:0]           q_in,
    output logic [tun_pkg::ROOT_W-1:0] p_out,
    output logic [QUO_W-1:0]           dl_out,
    output logic [QUO_W-1:0]           q_out
);
    import tun_pkg::*;

    logic [ROOT_W:0]   cur;
    logic              ge;
    logic [ROOT_W-1:0] p_next;
    logic [QUO_W-1:0]  dl_next;
    logic [QUO_W-1:0]  q_next;
    logic [ROOT_W-1:0] p_reg;
    logic [QUO_W-1:0]  dl_reg;
    logic [QUO_W-1:0]  q_reg;

    // one restoring division step, one quotient bit
    always_comb
    begin
        cur     = {p_in, dl_in[QUO_W-1]};
        ge      = (cur >= {1'b0, m_in});
        p_next  = ge ? ROOT_W'(cur - {1'b0, m_in}) : cur[ROOT_W-1:0];
        dl_next = {dl_in[QUO_W-2:0], 1'b0};
        q_next  = {q_in[QUO_W-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg  <= p_next;
            dl_reg <= dl_next;
            q_reg  <= q_next;
        end
    end

    assign p_out  = p_reg;
    assign dl_out = dl_reg;
    assign q_out  = q_reg;

endmodule

FILE: src/triangle_unit_normal.sv
// channel   | dir | contents
// s_axis    | in  | tdata: ax ay az bx by_coord bz cx cy cz, 16 bits each
// m_axis    | out | tdata: nx ny nz (Q1.14), tuser: degenerate
//
// one triangle per cycle unless the output stalls; the pipeline is 8 front stages
// (edges, products, cross, magnitude, length, shift, squares, sum), one
// cell per root bit of the 32-stage square root, a setup stage, one cell
// per quotient bit (FRAC_BITS + 1) of the divider and the output register.
// rst_n clears only the valid bits. a stalled output freezes the whole
// pipeline, s_axis_tready follows the output register being free or taken.
module triangle_unit_normal #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [143:0] s_axis_tdata,   // ax, ay, az, bx, by_coord, bz, cx, cy, cz
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [47:0]  m_axis_tdata,   // nx, ny, nz
    output logic         m_axis_tuser    // degenerate
);
    import tun_pkg::*;

    localparam int XW  = (COORD_BITS > 16) ? COORD_BITS : 16;
    localparam int EW  = COORD_BITS + 1;
    localparam int PW  = 2 * EW;
    localparam int CW  = PW + 1;
    localparam int LW  = $clog2(CW + 1);
    localparam int QW  = FRAC_BITS + 1;
    localparam int DW  = QW + ROOT_W;
    localparam int OW  = (QW > 16) ? QW : 16;
    localparam int NST = 8 + ROOT_W + 1 + QW + 1;

    function automatic logic [LW-1:0] bit_len(input logic [CW-1:0] v);
        logic [LW-1:0] n;
        n = '0;
        for (int i = 0; i < CW; i++)
        begin
            if (v[i])
                n = LW'(i + 1);
        end
        return n;
    endfunction

    logic                 en;
    logic [NST-1:0]       vld_reg;

    logic signed [COORD_BITS-1:0] crd [9];
    logic signed [EW-1:0] e1_reg [3];
    logic signed [EW-1:0] e2_reg [3];
    logic signed [PW-1:0] prod_reg [6];
    logic signed [CW-1:0] cross_reg [3];
    logic [CW-1:0]        mag4_reg [3];
    logic [3:0]           fl4_reg;
    logic [CW-1:0]        mag5_reg [3];
    logic [LW-1:0]        len5_reg;
    logic [3:0]           fl5_reg;
    logic [MAG_W-1:0]     nm6_reg [3];
    logic [3:0]           fl6_reg;
    logic [SQ_W-1:0]      sq7_reg [3];
    logic [MAG_W-1:0]     nm7_reg [3];
    logic [3:0]           fl7_reg;
    logic [SUM_W-1:0]     sum8_reg;
    logic [MAG_W-1:0]     nm8_reg [3];
    logic [3:0]           fl8_reg;

    logic [MAG_W-1:0]     nm_line_reg [ROOT_W][3];
    logic [3:0]           fl_line_reg [ROOT_W];

    logic [SUM_W-1:0]     s_w    [ROOT_W+1];
    logic [REM_W-1:0]     rem_w  [ROOT_W+1];
    logic [ROOT_W-1:0]    root_w [ROOT_W+1];

    logic [ROOT_W-1:0]    m_line_reg [QW+1];
    logic [3:0]           fl_div_reg [QW+1];
    logic [ROOT_W-1:0]    p_w  [QW+1][3];
    logic [QW-1:0]        dl_w [QW+1][3];
    logic [QW-1:0]        q_w  [QW+1][3];
    logic [ROOT_W-1:0]    p0_reg  [3];
    logic [QW-1:0]        dl0_reg [3];

    logic [15:0]          nout_reg [3];
    logic                 degen_reg;

    logic [DW-1:0]        dvd [3];
    logic [CW+MAG_W-1:0]  wide [3];
    logic [15:0]          nres [3];
    logic [OW-1:0]        qe [3];

    assign en            = !vld_reg[NST-1] || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NST-2:0], s_axis_tvalid};
    end

    // upper field bits beyond COORD_BITS are ignored
    always_comb
    begin
        for (int i = 0; i < 9; i++)
            crd[i] = COORD_BITS'(XW'(s_axis_tdata[16*i +: 16]));
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            wide[i] = {mag5_reg[i], MAG_W'(0)} >> len5_reg;
            dvd[i]  = (DW'(nm_line_reg[ROOT_W-1][i]) << FRAC_BITS)
                      + DW'(root_w[ROOT_W] >> 1);
            qe[i]   = OW'(q_w[QW][i]);
            nres[i] = fl_div_reg[QW][i] ? 16'(-qe[i]) : 16'(qe[i]);
        end
    end

    // front stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e1_reg[i] <= EW'(crd[3+i]) - EW'(crd[i]);
                e2_reg[i] <= EW'(crd[6+i]) - EW'(crd[i]);
            end
            prod_reg[0] <= e1_reg[1] * e2_reg[2];
            prod_reg[1] <= e1_reg[2] * e2_reg[1];
            prod_reg[2] <= e1_reg[2] * e2_reg[0];
            prod_reg[3] <= e1_reg[0] * e2_reg[2];
            prod_reg[4] <= e1_reg[0] * e2_reg[1];
            prod_reg[5] <= e1_reg[1] * e2_reg[0];
            for (int i = 0; i < 3; i++)
            begin
                cross_reg[i] <= CW'(prod_reg[2*i]) - CW'(prod_reg[2*i+1]);
                mag4_reg[i]  <= cross_reg[i][CW-1] ? CW'(-cross_reg[i]) : CW'(cross_reg[i]);
                fl4_reg[i]   <= cross_reg[i][CW-1];
            end
            fl4_reg[3] <= (cross_reg[0] == '0) && (cross_reg[1] == '0)
                          && (cross_reg[2] == '0);
            mag5_reg <= mag4_reg;
            len5_reg <= bit_len(mag4_reg[0] | mag4_reg[1] | mag4_reg[2]);
            fl5_reg  <= fl4_reg;
            // mag * 2^(31 - len): right or left shift in one
            for (int i = 0; i < 3; i++)
            begin
                nm6_reg[i] <= wide[i][MAG_W-1:0];
                sq7_reg[i] <= nm6_reg[i] * nm6_reg[i];
            end
            fl6_reg  <= fl5_reg;
            nm7_reg  <= nm6_reg;
            fl7_reg  <= fl6_reg;
            sum8_reg <= SUM_W'(sq7_reg[0]) + SUM_W'(sq7_reg[1]) + SUM_W'(sq7_reg[2]);
            nm8_reg  <= nm7_reg;
            fl8_reg  <= fl7_reg;
        end
    end

    // side lines alongside the sqrt and divider cells
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nm_line_reg[0] <= nm8_reg;
            fl_line_reg[0] <= fl8_reg;
            for (int k = 1; k < ROOT_W; k++)
            begin
                nm_line_reg[k] <= nm_line_reg[k-1];
                fl_line_reg[k] <= fl_line_reg[k-1];
            end
            m_line_reg[0] <= root_w[ROOT_W];
            fl_div_reg[0] <= fl_line_reg[ROOT_W-1];
            for (int k = 1; k <= QW; k++)
            begin
                m_line_reg[k] <= m_line_reg[k-1];
                fl_div_reg[k] <= fl_div_reg[k-1];
            end
            for (int i = 0; i < 3; i++)
            begin
                p0_reg[i]  <= dvd[i][DW-1:QW];
                dl0_reg[i] <= dvd[i][QW-1:0];
            end
        end
    end

    assign s_w[0]    = sum8_reg;
    assign rem_w[0]  = '0;
    assign root_w[0] = '0;

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sqrt
        tun_sqrt_cell u_cell (
            .clk      (clk),
            .en       (en),
            .s_in     (s_w[k]),
            .rem_in   (rem_w[k]),
            .root_in  (root_w[k]),
            .s_out    (s_w[k+1]),
            .rem_out  (rem_w[k+1]),
            .root_out (root_w[k+1])
        );
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        assign p_w[0][i]  = p0_reg[i];
        assign dl_w[0][i] = dl0_reg[i];
        assign q_w[0][i]  = '0;
        for (genvar k = 0; k < QW; k++)
        begin : g_div
            tun_div_cell #(
                .QUO_W (QW)
            ) u_cell (
                .clk    (clk),
                .en     (en),
                .m_in   (m_line_reg[k]),
                .p_in   (p_w[k][i]),
                .dl_in  (dl_w[k][i]),
                .q_in   (q_w[k][i]),
                .p_out  (p_w[k+1][i]),
                .dl_out (dl_w[k+1][i]),
                .q_out  (q_w[k+1][i])
            );
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                nout_reg[i] <= fl_div_reg[QW][3] ? 16'd0 : nres[i];
            degen_reg <= fl_div_reg[QW][3];
        end
    end

    assign m_axis_tvalid = vld_reg[NST-1];
    assign m_axis_tdata  = {nout_reg[2], nout_reg[1], nout_reg[0]};
    assign m_axis_tuser  = degen_reg;

endmodule
